FILE: src/rev_ramped_gain_blend_assert.svh
// Assertion macros for the ramped gain blend block.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef REV_RAMPED_GAIN_BLEND_ASSERT_SVH
`define REV_RAMPED_GAIN_BLEND_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define RRGB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication, disabled while reset is asserted
`define RRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define RRGB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/rrgb_pkg.sv
// Shared types and constants for the ramped gain blend block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rrgb_pkg;

    // Field widths
    localparam int unsigned GainW    = 10;
    localparam int unsigned SpeedW   = 16;
    localparam int unsigned ThrW     = 8;
    localparam int unsigned RevW     = 8;
    localparam int unsigned ProgW    = 16;
    localparam int unsigned CfgIdxW  = 4;
    localparam int unsigned CfgDataW = 16;

    // Divider: the quotient never exceeds the gain distance, so GainW bits suffice
    localparam int unsigned ProdW    = GainW + ProgW;
    localparam int unsigned DivSteps = GainW;
    localparam int unsigned StepW    = $clog2(DivSteps);

    // Queue between front and back
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // Gain of 1.00 in Q2.8
    localparam logic [GainW-1:0] UnityGain = 10'd256;

    // Operation codes
    localparam logic OpUpdate = 1'b0;
    localparam logic OpReset  = 1'b1;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegBaseGain   = 4'd0;
    localparam logic [CfgIdxW-1:0] RegSpeedThr   = 4'd1;
    localparam logic [CfgIdxW-1:0] RegThrottleThr = 4'd2;
    localparam logic [CfgIdxW-1:0] RegRampRevs   = 4'd3;

    // Register reset values
    localparam logic [GainW-1:0]  ResetBaseGain   = 10'd128;
    localparam logic [SpeedW-1:0] ResetSpeedThr   = 16'd9000;
    localparam logic [ThrW-1:0]   ResetThrottleThr = 8'd30;
    localparam logic [ProgW-1:0]  ResetRampRevs   = 16'd50;

    typedef struct packed {
        logic [GainW-1:0]  base_gain;
        logic [SpeedW-1:0] speed_threshold;
        logic [ThrW-1:0]   throttle_threshold;
        logic [ProgW-1:0]  ramp_revolutions;
    } cfg_t;

    // One classified item handed from front to back
    typedef struct packed {
        logic [ProgW-1:0] progress;
        logic [ProgW-1:0] span;
        logic [GainW-1:0] base_gain;
        logic             complete;
    } entry_t;

endpackage

`default_nettype wire

FILE: src/rrgb_front.sv
// Front part: accepts items, updates ramp progress and the revolution mark.
// Depends on rrgb_pkg; pushes one entry per beat into rrgb_queue.
`timescale 1ns / 1ps
`default_nettype none

module rrgb_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         operation,
    input  wire logic [rrgb_pkg::SpeedW-1:0]  engine_speed,
    input  wire logic [rrgb_pkg::ThrW-1:0]    throttle,
    input  wire logic [rrgb_pkg::RevW-1:0]    revolution_count,
    input  wire rrgb_pkg::cfg_t               cfg,
    input  wire logic                         q_full,
    output logic                              q_push,
    output rrgb_pkg::entry_t                  q_entry
);

    logic [rrgb_pkg::ProgW-1:0] progress_reg;
    logic [rrgb_pkg::ProgW-1:0] progress_next;
    logic [rrgb_pkg::RevW-1:0]  last_rev_reg;

    logic                       accept;
    logic [rrgb_pkg::ProgW-1:0] span;
    logic [rrgb_pkg::ProgW-1:0] clamped;
    logic [rrgb_pkg::RevW-1:0]  delta;
    logic                       in_band;
    logic [rrgb_pkg::ProgW:0]   sum;
    logic [rrgb_pkg::ProgW-1:0] rise;
    logic [rrgb_pkg::ProgW-1:0] fall;

    // Take a beat whenever the queue has room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the item and work out the new progress
    always_comb
    begin
        span    = (cfg.ramp_revolutions == '0) ? rrgb_pkg::ProgW'(1) : cfg.ramp_revolutions;
        clamped = (progress_reg > span) ? span : progress_reg;
        delta   = revolution_count - last_rev_reg;
        in_band = (engine_speed >= cfg.speed_threshold)
                  && (throttle >= cfg.throttle_threshold);
        sum     = (rrgb_pkg::ProgW+1)'(clamped) + (rrgb_pkg::ProgW+1)'(delta);
        rise    = (sum > (rrgb_pkg::ProgW+1)'(span)) ? span : sum[rrgb_pkg::ProgW-1:0];
        fall    = (rrgb_pkg::ProgW'(delta) >= clamped) ? '0
                  : clamped - rrgb_pkg::ProgW'(delta);

        if (operation == rrgb_pkg::OpReset)
        begin
            progress_next = '0;
        end
        else if (in_band)
        begin
            progress_next = rise;
        end
        else
        begin
            progress_next = fall;
        end
    end

    // Hand the result of the update to the back part
    assign q_push            = accept;
    assign q_entry.progress  = progress_next;
    assign q_entry.span      = span;
    assign q_entry.base_gain = cfg.base_gain;
    assign q_entry.complete  = (progress_next >= span);

    // Advance ramp state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= '0;
            last_rev_reg <= '0;
        end
        else if (accept)
        begin
            progress_reg <= progress_next;
            last_rev_reg <= revolution_count;
        end
    end

endmodule

`default_nettype wire

FILE: src/rrgb_queue.sv
// Short FIFO of classified entries between the front and back parts.
// Depends on rrgb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rrgb_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rrgb_pkg::entry_t push_entry,
    input  wire logic             pop,
    output rrgb_pkg::entry_t      head,
    output logic                  full,
    output logic                  empty
);

    rrgb_pkg::entry_t               slot_reg [rrgb_pkg::QDepth];
    logic [rrgb_pkg::QPtrW-1:0]     wr_ptr_reg;
    logic [rrgb_pkg::QPtrW-1:0]     rd_ptr_reg;
    logic [rrgb_pkg::QCntW-1:0]     count_reg;
    logic [rrgb_pkg::QCntW-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == rrgb_pkg::QCntW'(rrgb_pkg::QDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == rrgb_pkg::QPtrW'(rrgb_pkg::QDepth - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == rrgb_pkg::QPtrW'(rrgb_pkg::QDepth - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: src/rrgb_back.sv
// Back part: scales the gain distance by progress, divides by the span
// serially and holds the result beat. Depends on rrgb_pkg and the assert macros.
`timescale 1ns / 1ps
`default_nettype none
`include "rev_ramped_gain_blend_assert.svh"

module rrgb_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire rrgb_pkg::entry_t             q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [rrgb_pkg::GainW-1:0]        gain,
    output logic                              ramp_complete
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [rrgb_pkg::StepW-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;

    logic                        down_reg, down_next;
    logic [rrgb_pkg::GainW-1:0]  d_reg, d_next;
    logic [rrgb_pkg::GainW-1:0]  base_reg, base_next;
    logic [rrgb_pkg::ProgW-1:0]  prog_reg, prog_next;
    logic [rrgb_pkg::ProgW-1:0]  span_reg, span_next;
    logic                        complete_reg, complete_next;
    logic [rrgb_pkg::ProgW-1:0]  rem_reg, rem_next;
    logic [rrgb_pkg::GainW-1:0]  quo_reg, quo_next;
    logic [rrgb_pkg::GainW-1:0]  gain_reg, gain_next;
    logic                        out_complete_reg, out_complete_next;

    logic [rrgb_pkg::ProdW-1:0]  product;
    logic [rrgb_pkg::ProgW:0]    trial;
    logic [rrgb_pkg::ProgW:0]    diff;
    logic                        trial_ge;
    logic                        head_down;
    logic                        out_free;
    logic                        load_out;

    assign head_down = (q_head.base_gain > rrgb_pkg::UnityGain);
    assign product   = rrgb_pkg::ProdW'(d_reg) * rrgb_pkg::ProdW'(prog_reg);
    assign trial     = {rem_reg, quo_reg[rrgb_pkg::GainW-1]};
    assign diff      = trial - (rrgb_pkg::ProgW+1)'(span_reg);
    assign trial_ge  = (trial >= (rrgb_pkg::ProgW+1)'(span_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_DONE) && out_free;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;

    // Sequence one entry: fetch, multiply, divide, deliver
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        down_next         = down_reg;
        d_next            = d_reg;
        base_next         = base_reg;
        prog_next         = prog_reg;
        span_next         = span_reg;
        complete_next     = complete_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        gain_next         = gain_reg;
        out_complete_next = out_complete_reg;
        out_valid_next    = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    down_next     = head_down;
                    d_next        = head_down ? q_head.base_gain - rrgb_pkg::UnityGain
                                              : rrgb_pkg::UnityGain - q_head.base_gain;
                    base_next     = q_head.base_gain;
                    prog_next     = q_head.progress;
                    span_next     = q_head.span;
                    complete_next = q_head.complete;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                // The upper part is below the span because the quotient fits GainW bits
                rem_next   = product[rrgb_pkg::ProdW-1:rrgb_pkg::GainW];
                quo_next   = product[rrgb_pkg::GainW-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? diff[rrgb_pkg::ProgW-1:0] : trial[rrgb_pkg::ProgW-1:0];
                quo_next = {quo_reg[rrgb_pkg::GainW-2:0], trial_ge};
                if (step_reg == rrgb_pkg::StepW'(rrgb_pkg::DivSteps - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    gain_next         = down_reg ? base_reg - quo_reg : base_reg + quo_reg;
                    out_complete_next = complete_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        down_reg         <= down_next;
        d_reg            <= d_next;
        base_reg         <= base_next;
        prog_reg         <= prog_next;
        span_reg         <= span_next;
        complete_reg     <= complete_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        gain_reg         <= gain_next;
        out_complete_reg <= out_complete_next;
    end

    assign out_valid     = out_valid_reg;
    assign gain          = gain_reg;
    assign ramp_complete = out_complete_reg;

    // Partial remainder stays below the divisor throughout the division
    `RRGB_ASSERT_SAME(a_rem_below_span, clk, rst_n, state_reg == S_DIV, rem_reg < span_reg)
    // Quotient never exceeds the gain distance, so the result stays in range
    `RRGB_ASSERT_SAME(a_quo_in_range, clk, rst_n, state_reg == S_DONE, quo_reg <= d_reg)
    // Last divide step hands over to delivery
    `RRGB_ASSERT_NEXT(a_div_ends, clk, rst_n,
        (state_reg == S_DIV) && (step_reg == rrgb_pkg::StepW'(rrgb_pkg::DivSteps - 1)),
        state_reg == S_DONE)
    // A free output slot takes the result and frees the sequencer
    `RRGB_ASSERT_NEXT(a_deliver, clk, rst_n, load_out, out_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire

FILE: src/rev_ramped_gain_blend.sv
// Top level of the ramped gain blend block: configuration registers and the
// front, queue and back parts. Depends on rrgb_pkg, rrgb_front, rrgb_queue, rrgb_back.
`timescale 1ns / 1ps
`default_nettype none

// Ramped gain blend. Each input beat either updates the ramp from engine
// speed, throttle and the 8-bit crank revolution counter, or resets the ramp
// (operation 1) and resyncs the counter. Every input beat yields exactly one
// output beat with a Q2.8 gain interpolated from base_gain toward 1.00 and a
// flag that is set once progress reaches the span. The front takes a beat and
// queues it (two entries); the back then handles each item in turn: it
// fetches the entry, does the 10x16 multiply, runs 10 restoring divide steps
// and loads the output register once it is free, and it takes the next entry
// only after that load, so the serial divider bounds the sustained throughput.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods; indexes above 3 are ignored.
module rev_ramped_gain_blend
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrgb_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [rrgb_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           operation,
    input  wire logic [rrgb_pkg::SpeedW-1:0]    engine_speed,
    input  wire logic [rrgb_pkg::ThrW-1:0]      throttle,
    input  wire logic [rrgb_pkg::RevW-1:0]      revolution_count,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [rrgb_pkg::GainW-1:0]          gain,
    output logic                                ramp_complete
);

    rrgb_pkg::cfg_t   cfg_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    rrgb_pkg::entry_t q_entry;
    rrgb_pkg::entry_t q_head;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_gain          <= rrgb_pkg::ResetBaseGain;
            cfg_reg.speed_threshold    <= rrgb_pkg::ResetSpeedThr;
            cfg_reg.throttle_threshold <= rrgb_pkg::ResetThrottleThr;
            cfg_reg.ramp_revolutions   <= rrgb_pkg::ResetRampRevs;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrgb_pkg::RegBaseGain:
                    cfg_reg.base_gain <= cfg_data[rrgb_pkg::GainW-1:0];
                rrgb_pkg::RegSpeedThr:
                    cfg_reg.speed_threshold <= cfg_data[rrgb_pkg::SpeedW-1:0];
                rrgb_pkg::RegThrottleThr:
                    cfg_reg.throttle_threshold <= cfg_data[rrgb_pkg::ThrW-1:0];
                rrgb_pkg::RegRampRevs:
                    cfg_reg.ramp_revolutions <= cfg_data[rrgb_pkg::ProgW-1:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    rrgb_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .engine_speed     (engine_speed),
        .throttle         (throttle),
        .revolution_count (revolution_count),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (q_entry)
    );

    rrgb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    rrgb_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gain          (gain),
        .ramp_complete (ramp_complete)
    );

endmodule

`default_nettype wire
